// ===== rtl/sfsg_pkg.sv =====
// ----------------------------------------------------------------------------
// sfsg_pkg: shared types and codes for the stroke font segment generator
// Item formats, configuration and pen state structs, opcode and
// direction codes.
// ----------------------------------------------------------------------------
package sfsg_pkg;

  // Item op codes
  typedef enum logic [1:0] {
    OP_BEGIN     = 2'd0,
    OP_STROKE    = 2'd1,
    OP_CHAR_DONE = 2'd2,
    OP_RESERVED  = 2'd3
  } op_t;

  // Stroke record opcodes (byte a bit 7, byte b bit 7)
  typedef enum logic [1:0] {
    CODE_END  = 2'd0,
    CODE_NOP  = 2'd1,
    CODE_MOVE = 2'd2,
    CODE_LINE = 2'd3
  } code_t;

  // Text direction register codes
  typedef enum logic [1:0] {
    DIR_NORMAL = 2'd0,
    DIR_CW     = 2'd1,
    DIR_CCW    = 2'd2,
    DIR_CCW_ALT = 2'd3
  } dir_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_DIR   = 2'd1,
    REG_COLOR = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  // Result kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [3:0] SCALE_MAX   = 4'd10;
  localparam logic [3:0] SCALE_RESET = 4'd1;
  localparam logic [7:0] COLOR_RESET = 8'd15;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]         record_byte_a;
    logic [7:0]         record_byte_b;
    logic [7:0]         glyph_width;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic [7:0]         segment_color;
    logic [11:0]        char_advance;
    logic signed [15:0] total_advance;
  } out_item_t;

  typedef struct packed {
    logic [3:0] scale;
    dir_t       dir;
    logic [7:0] color;
  } cfg_t;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic        glyph_ended;
    logic [15:0] advance_sum;
  } pen_state_t;

endpackage

// ===== rtl/sfsg_step.sv =====
// ----------------------------------------------------------------------------
// sfsg_step: per-item step logic
// Given the current pen state, configuration and one item, computes the
// next pen state and the result item, if any.
// ----------------------------------------------------------------------------
module sfsg_step (
  input  sfsg_pkg::in_item_t   item,
  input  sfsg_pkg::cfg_t       cfg,
  input  sfsg_pkg::pen_state_t st,
  output sfsg_pkg::pen_state_t st_next,
  output logic                 emit,
  output sfsg_pkg::out_item_t  result
);
  import sfsg_pkg::*;

  logic               scale_zero;
  code_t              code;
  logic signed [11:0] dx_s;
  logic signed [11:0] dy_s;
  logic [15:0]        dx;
  logic [15:0]        dy;
  logic [15:0]        nx;
  logic [15:0]        ny;
  logic [11:0]        adv;
  logic [15:0]        adv16;
  logic [15:0]        org_x_adv;
  logic [15:0]        org_y_adv;
  logic [15:0]        sum_adv;

  assign scale_zero = (cfg.scale == 4'd0);
  assign code = code_t'({item.record_byte_a[7], item.record_byte_b[7]});

  // Scaled 7-bit signed coordinates, sign-extended to 16 bits
  assign dx_s = $signed({{5{item.record_byte_a[6]}}, item.record_byte_a[6:0]})
              * $signed({8'd0, cfg.scale});
  assign dy_s = $signed({{5{item.record_byte_b[6]}}, item.record_byte_b[6:0]})
              * $signed({8'd0, cfg.scale});
  assign dx = {{4{dx_s[11]}}, dx_s};
  assign dy = {{4{dy_s[11]}}, dy_s};

  // Map glyph space onto screen by direction
  always_comb begin
    case (cfg.dir)
      DIR_NORMAL: begin
        nx = st.origin_x + dx;
        ny = st.origin_y - dy;
      end
      DIR_CW: begin
        nx = st.origin_x + dy;
        ny = st.origin_y + dx;
      end
      default: begin
        nx = st.origin_x - dy;
        ny = st.origin_y - dx;
      end
    endcase
  end

  // Character advance
  assign adv       = {4'd0, item.glyph_width} * {8'd0, cfg.scale};
  assign adv16     = {4'd0, adv};
  assign org_x_adv = (cfg.dir == DIR_NORMAL) ? st.origin_x + adv16 : st.origin_x;
  assign org_y_adv = (cfg.dir == DIR_NORMAL) ? st.origin_y : st.origin_y + adv16;
  assign sum_adv   = st.advance_sum + adv16;

  // Item decode and state update
  always_comb begin
    st_next = st;
    emit    = 1'b0;
    result  = '0;
    case (op_t'(item.op))
      OP_BEGIN: begin
        st_next.origin_x    = item.start_x;
        st_next.origin_y    = item.start_y;
        st_next.pen_x       = item.start_x;
        st_next.pen_y       = item.start_y;
        st_next.advance_sum = 16'd0;
        st_next.glyph_ended = 1'b0;
      end
      OP_STROKE: begin
        if (!scale_zero && !st.glyph_ended) begin
          case (code)
            CODE_END: begin
              st_next.glyph_ended = 1'b1;
            end
            CODE_MOVE: begin
              st_next.pen_x = nx;
              st_next.pen_y = ny;
            end
            CODE_LINE: begin
              st_next.pen_x        = nx;
              st_next.pen_y        = ny;
              emit                 = 1'b1;
              result.kind          = KIND_SEGMENT;
              result.from_x        = st.pen_x;
              result.from_y        = st.pen_y;
              result.to_x          = nx;
              result.to_y          = ny;
              result.segment_color = cfg.color;
            end
            default: begin
            end
          endcase
        end
      end
      OP_CHAR_DONE: begin
        st_next.origin_x    = org_x_adv;
        st_next.origin_y    = org_y_adv;
        st_next.pen_x       = org_x_adv;
        st_next.pen_y       = org_y_adv;
        st_next.advance_sum = sum_adv;
        st_next.glyph_ended = 1'b0;
        emit                 = !scale_zero;
        result.kind          = KIND_ADVANCE;
        result.char_advance  = adv;
        result.total_advance = sum_adv;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/stroke_font_segment_generator_unit.sv =====
// ----------------------------------------------------------------------------
// stroke_font_segment_generator_unit: stroke records to line segments
// Top level: input register, step logic, pen state and result register.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while in_stall is low; an accepted item
// is held in the input register until the step logic processes it, which
// loads its result into the result register. The per-item path is a 7x4
// multiply per coordinate followed by one 16-bit add, and the pen state
// feeds back around that single stage. Items that produce no result (begin
// string, move-to, end, ignored records, any item while scale is 0) pass
// even while a result waits on out_stall; a result-producing item waits
// until the result register is free. Configuration must be written only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stroke_font_segment_generator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfsg_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfsg_pkg::out_item_t out_data,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import sfsg_pkg::*;

  cfg_t       cfg;
  pen_state_t state;
  pen_state_t state_next;
  in_item_t   in_q;
  logic       in_q_valid;
  out_item_t  out_q;
  logic       emit;
  out_item_t  result;
  logic       advance;
  logic       accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale <= SCALE_RESET;
      cfg.dir   <= DIR_NORMAL;
      cfg.color <= COLOR_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_SCALE: cfg.scale <= (cfg_data[3:0] > SCALE_MAX) ? SCALE_MAX : cfg_data[3:0];
        REG_DIR:   cfg.dir   <= dir_t'(cfg_data[1:0]);
        REG_COLOR: cfg.color <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Step logic
  sfsg_step u_step (
    .item    (in_q),
    .cfg     (cfg),
    .st      (state),
    .st_next (state_next),
    .emit    (emit),
    .result  (result)
  );

  // Flow control
  assign advance  = in_q_valid && (!out_valid || !out_stall || !emit);
  assign in_stall = in_q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
  end

  // Pen state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign out_data = out_q;

`ifndef SYNTHESIS
  // Stall only ever comes from a held item in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid)
    else $error("in_stall without a held item");

  // Scale register never exceeds its saturation limit
  a_scale_sat: assert property (@(posedge clk) disable iff (rst)
    cfg.scale <= SCALE_MAX)
    else $error("scale above maximum");

  // A waiting result is not overwritten by items that pass by
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_q))
    else $error("waiting result lost or changed");

  // Normal direction advances along x only
  a_adv_axis: assert property (@(posedge clk) disable iff (rst)
    advance && (in_q.op == OP_CHAR_DONE) && (cfg.dir == DIR_NORMAL)
    |=> $stable(state.origin_y))
    else $error("normal-direction advance moved y origin");

  // Begin string always reopens the glyph
  a_begin_clear: assert property (@(posedge clk) disable iff (rst)
    advance && (in_q.op == OP_BEGIN) |=> !state.glyph_ended
      && (state.advance_sum == 16'd0))
    else $error("begin string left stale glyph state");
`endif

endmodule
